// File: rtl/tfc_pkg.sv
// shared types and constants for the texel format converter
package tfc_pkg;

	localparam int unsigned FMT_W   = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TEXEL_W = 16;

	// source transfer formats
	typedef enum logic [FMT_W-1:0] {
		FMT_ALPHA     = 3'd0,
		FMT_LUMINANCE = 3'd1,
		FMT_LUM_ALPHA = 3'd2,
		FMT_RED       = 3'd3,
		FMT_GREEN     = 3'd4,
		FMT_BLUE      = 3'd5,
		FMT_RGB       = 3'd6,
		FMT_RGBA      = 3'd7
	} src_fmt_t;

	// base internal formats, codes above rgba pack as rgba
	typedef enum logic [FMT_W-1:0] {
		BASE_RGB       = 3'd0,
		BASE_LUMINANCE = 3'd1,
		BASE_ALPHA     = 3'd2,
		BASE_LUM_ALPHA = 3'd3,
		BASE_INTENSITY = 3'd4,
		BASE_RGBA      = 3'd5
	} base_fmt_t;

	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [BYTE_W-1:0] COLOUR_ZERO  = 8'h00;
	localparam logic [11:0]       WHITE_RGB444 = 12'hFFF;

endpackage

// File: rtl/tfc_if.sv
// stream interfaces for source pixels and packed texels
interface tfc_pixel_if import tfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FMT_W-1:0]  source_format;
	logic [FMT_W-1:0]  internal_base;
	logic [BYTE_W-1:0] byte0;
	logic [BYTE_W-1:0] byte1;
	logic [BYTE_W-1:0] byte2;
	logic [BYTE_W-1:0] byte3;

	modport source (output valid, source_format, internal_base, byte0, byte1, byte2, byte3,
		input ready);
	modport sink (input valid, source_format, internal_base, byte0, byte1, byte2, byte3,
		output ready);
endinterface

interface tfc_texel_if import tfc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TEXEL_W-1:0] texel;

	modport source (output valid, texel, input ready);
	modport sink (input valid, texel, output ready);
endinterface

// File: rtl/texel_format_converter.sv
// Texel format converter: one source pixel of up to four bytes in, one packed 16-bit texel out.
// The pixel is widened to RGBA (luminance to R=G=B, missing alpha 255, missing colour 0), then
// packed as RGB565 for rgb and luminance bases or ARGB4444 for the rest, each channel rounded as
// (c*(2^n-1)+127)/255. Throughput is one pixel per clock while the output is not held off. Each
// pixel passes the input register, then the result register, with rounding and packing between.
// A held-off output stalls the input only when both registers are full. No reset-time sweep.
module texel_format_converter import tfc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	tfc_pixel_if.sink       pixel,
	tfc_texel_if.source     texel
);

	logic              valid_s1;
	logic [FMT_W-1:0]  fmt_s1;
	logic [FMT_W-1:0]  base_s1;
	logic [BYTE_W-1:0] b0_s1, b1_s1, b2_s1, b3_s1;
	logic              valid_s2;
	logic [TEXEL_W-1:0] texel_s2;

	logic stall_s2;
	logic load_s1;
	logic [BYTE_W-1:0] r, g, b, a;
	logic [TEXEL_W-1:0] texel_d;

	// rounded narrowing of one channel to n bits, divide by 255 through reciprocal
	function automatic logic [5:0] narrow(input logic [BYTE_W-1:0] c, input logic [2:0] n);
		logic [5:0]  top;
		logic [15:0] x;
		logic [15:0] q;
		top = 6'((7'd1 << n) - 7'd1);
		x = 16'(c) * 16'(top) + 16'd127;
		q = (x + 16'd1 + (x >> 8)) >> 8;
		return q[5:0];
	endfunction

	assign stall_s2 = valid_s2 && !texel.ready;
	assign pixel.ready = !(valid_s1 && stall_s2);
	assign load_s1 = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel.ready)
				valid_s1 <= pixel.valid;
			if (!stall_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			fmt_s1  <= pixel.source_format;
			base_s1 <= pixel.internal_base;
			b0_s1   <= pixel.byte0;
			b1_s1   <= pixel.byte1;
			b2_s1   <= pixel.byte2;
			b3_s1   <= pixel.byte3;
		end
		if (!stall_s2 && valid_s1)
			texel_s2 <= texel_d;
	end

	// expand to rgba
	always_comb begin
		r = COLOUR_ZERO;
		g = COLOUR_ZERO;
		b = COLOUR_ZERO;
		a = ALPHA_OPAQUE;
		case (src_fmt_t'(fmt_s1))
			FMT_ALPHA: a = b0_s1;
			FMT_LUMINANCE: begin
				r = b0_s1; g = b0_s1; b = b0_s1;
			end
			FMT_LUM_ALPHA: begin
				r = b0_s1; g = b0_s1; b = b0_s1; a = b1_s1;
			end
			FMT_RED:   r = b0_s1;
			FMT_GREEN: g = b0_s1;
			FMT_BLUE:  b = b0_s1;
			FMT_RGB: begin
				r = b0_s1; g = b1_s1; b = b2_s1;
			end
			FMT_RGBA: begin
				r = b0_s1; g = b1_s1; b = b2_s1; a = b3_s1;
			end
			default: begin
				r = b0_s1; g = b1_s1; b = b2_s1; a = b3_s1;
			end
		endcase
	end

	// pack by base format, luminance and intensity come from red
	always_comb begin
		logic [5:0] r5, g6, b5, l5, l6, a4, r4, g4, b4;
		r5 = narrow(r, 3'd5);
		g6 = narrow(g, 3'd6);
		b5 = narrow(b, 3'd5);
		l5 = r5;
		l6 = narrow(r, 3'd6);
		a4 = narrow(a, 3'd4);
		r4 = narrow(r, 3'd4);
		g4 = narrow(g, 3'd4);
		b4 = narrow(b, 3'd4);
		case (base_fmt_t'(base_s1))
			BASE_RGB:       texel_d = {r5[4:0], g6, b5[4:0]};
			BASE_LUMINANCE: texel_d = {l5[4:0], l6, l5[4:0]};
			BASE_ALPHA:     texel_d = {a4[3:0], WHITE_RGB444};
			BASE_LUM_ALPHA: texel_d = {a4[3:0], r4[3:0], r4[3:0], r4[3:0]};
			BASE_INTENSITY: texel_d = {r4[3:0], r4[3:0], r4[3:0], r4[3:0]};
			default:        texel_d = {a4[3:0], r4[3:0], g4[3:0], b4[3:0]};
		endcase
	end

	assign texel.valid = valid_s2;
	assign texel.texel = texel_s2;

	// a result appears only from a pixel held in the input register
	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result register filled without an input pixel");

	// input register holds its pixel while the result register is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && stall_s2) |=> (valid_s1 && $stable(fmt_s1) && $stable(base_s1)
			&& $stable(b0_s1) && $stable(b1_s1) && $stable(b2_s1) && $stable(b3_s1)))
		else $error("input register changed during a stall");

	// input is refused only when both stages are full and the output is stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (valid_s1 && valid_s2 && !texel.ready))
		else $error("input refused without a full pipeline");

	// a blocked result keeps its value
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall_s2 |=> (valid_s2 && $stable(texel_s2)))
		else $error("result register changed during a stall");

endmodule
